FILE: design/hsl_pkg.sv
// Package for the HSL to RGB565 converter: payload word types, fixed constants
// and the small divide-by-fifteen helper used by the output stage.
// No dependencies.
package hsl_pkg;

  // Default number of fraction bits in saturation and lightness.
  localparam int FRAC_BITS_DEF = 10;

  // Hue geometry in whole degrees.
  localparam int HUE_LIMIT   = 360;
  localparam int SECTOR_DEG  = 60;
  localparam int DOUBLE_DEG  = 120;
  localparam int HALF_SECTOR = 30;

  // Channel ceilings and the scaled values at which they are reached.
  localparam int RB_MAX       = 31;
  localparam int G_MAX        = 63;
  localparam int RB_SAT_LIMIT = 480;   // 15 * 32
  localparam int G_SAT_LIMIT  = 960;   // 15 * 64

  // Reciprocal of fifteen as 17 / 256, corrected by one compare.
  localparam int RECIP_MUL   = 17;
  localparam int RECIP_SHIFT = 8;
  localparam int DIVISOR     = 15;

  // The six 60-degree hue sectors.
  typedef enum logic [2:0] {
    SEC_RED_YEL   = 3'd0,
    SEC_YEL_GRN   = 3'd1,
    SEC_GRN_CYN   = 3'd2,
    SEC_CYN_BLU   = 3'd3,
    SEC_BLU_MAG   = 3'd4,
    SEC_MAG_RED   = 3'd5
  } sector_t;

  // Input word.
  typedef struct packed {
    logic [8:0]  hue;
    logic [10:0] saturation;
    logic [10:0] lightness;
  } hsl_in_t;

  // Result word.
  typedef struct packed {
    logic [15:0] color;
    logic        hue_error;
  } hsl_out_t;

  // Floor of u / 15 for u up to 1023.
  function automatic logic [6:0] div15(input logic [9:0] u);
    logic [14:0] prod;
    logic [6:0]  q0;
    logic [10:0] rem;
    prod = 15'(u) * 15'(RECIP_MUL);
    q0   = 7'(prod >> RECIP_SHIFT);
    rem  = 11'(u) - 11'(q0) * 11'(DIVISOR);
    if (rem >= 11'(DIVISOR)) begin
      div15 = q0 + 7'd1;
    end else begin
      div15 = q0;
    end
  endfunction

endpackage

FILE: design/hsl_to_rgb565.sv
// Top level of the HSL to RGB565 converter: a five-stage pipeline.
// Depends on hsl_pkg for the word types, constants and div15.
//
//   channel  ports                      direction  handshake
//   input    start, busy, in_word       in         taken when start and not busy
//   result   out_strobe, out_word       out        shown for one cycle, always taken
//
// One word enters every cycle; its result passes the registers of every stage in order before it leaves.
// The stages are clamp and sector, chroma multiply, channel multiply,
// offset add and scale, divide by fifteen with saturation and packing.
// busy stays low: the receiver cannot stall, so nothing ever holds the pipe.
// Reset (synchronous, active low) clears the valid bits of all stages.
module hsl_to_rgb565
  import hsl_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  hsl_in_t  in_word,
  output logic     out_strobe,
  output hsl_out_t out_word
);

  localparam int FW   = FRAC_BITS + 1;            // clamped fraction
  localparam int CMPW = (FRAC_BITS + 2 > 11) ? FRAC_BITS + 2 : 11;
  localparam int CXW  = 2 * FRAC_BITS + 1;        // chroma, at most 2^(2F)
  localparam int L6W  = FRAC_BITS + 7;            // lightness times 60
  localparam int PW   = 2 * FRAC_BITS + 8;        // signed channel sums

  // Valid and error bits travel with the data.
  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic e1_r, e2_r, e3_r, e4_r;

  // ---------------- Stage 1: clamp, sector and coefficients ----------------
  logic [CMPW-1:0] s_ext, l_ext, one_c;
  logic [FW-1:0]   s_c, l_c;
  sector_t         sector;
  logic [6:0]      t_deg;
  logic [5:0]      dev_deg, w_deg;
  logic signed [6:0] c_coef, x_coef, z_coef;
  logic signed [6:0] cr_nxt, cg_nxt, cb_nxt;
  logic [FW-1:0]   s1_r, l1_r;
  logic signed [6:0] cr1_r, cg1_r, cb1_r;

  assign busy  = 1'b0;
  assign s_ext = CMPW'(in_word.saturation);
  assign l_ext = CMPW'(in_word.lightness);
  assign one_c = CMPW'(1) << FRAC_BITS;
  assign s_c   = (s_ext > one_c) ? one_c[FW-1:0] : s_ext[FW-1:0];
  assign l_c   = (l_ext > one_c) ? one_c[FW-1:0] : l_ext[FW-1:0];

  // Sector from the hue and the position inside its 120-degree pair.
  always_comb begin
    if (in_word.hue < 9'(SECTOR_DEG)) begin
      sector = SEC_RED_YEL;
    end else if (in_word.hue < 9'(2 * SECTOR_DEG)) begin
      sector = SEC_YEL_GRN;
    end else if (in_word.hue < 9'(3 * SECTOR_DEG)) begin
      sector = SEC_GRN_CYN;
    end else if (in_word.hue < 9'(4 * SECTOR_DEG)) begin
      sector = SEC_CYN_BLU;
    end else if (in_word.hue < 9'(5 * SECTOR_DEG)) begin
      sector = SEC_BLU_MAG;
    end else begin
      sector = SEC_MAG_RED;
    end
    case (sector)
      SEC_RED_YEL, SEC_YEL_GRN: t_deg = 7'(in_word.hue);
      SEC_GRN_CYN, SEC_CYN_BLU: t_deg = 7'(in_word.hue - 9'(DOUBLE_DEG));
      default:                  t_deg = 7'(in_word.hue - 9'(2 * DOUBLE_DEG));
    endcase
    if (t_deg >= 7'(SECTOR_DEG)) begin
      dev_deg = 6'(t_deg - 7'(SECTOR_DEG));
    end else begin
      dev_deg = 6'(7'(SECTOR_DEG) - t_deg);
    end
    w_deg = 6'(SECTOR_DEG) - dev_deg;
  end

  // Each channel weight, minus the half-chroma offset, as a signed number.
  assign c_coef = 7'sd30;
  assign x_coef = $signed({1'b0, w_deg}) - 7'(HALF_SECTOR);
  assign z_coef = -7'sd30;

  always_comb begin
    case (sector)
      SEC_RED_YEL: begin cr_nxt = c_coef; cg_nxt = x_coef; cb_nxt = z_coef; end
      SEC_YEL_GRN: begin cr_nxt = x_coef; cg_nxt = c_coef; cb_nxt = z_coef; end
      SEC_GRN_CYN: begin cr_nxt = z_coef; cg_nxt = c_coef; cb_nxt = x_coef; end
      SEC_CYN_BLU: begin cr_nxt = z_coef; cg_nxt = x_coef; cb_nxt = c_coef; end
      SEC_BLU_MAG: begin cr_nxt = x_coef; cg_nxt = z_coef; cb_nxt = c_coef; end
      default:     begin cr_nxt = c_coef; cg_nxt = z_coef; cb_nxt = x_coef; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
    end
    e1_r  <= in_word.hue >= 9'(HUE_LIMIT);
    s1_r  <= s_c;
    l1_r  <= l_c;
    cr1_r <= cr_nxt;
    cg1_r <= cg_nxt;
    cb1_r <= cb_nxt;
  end

  // ---------------- Stage 2: chroma and lightness term ----------------
  logic [FW:0]     two_l, one_w, dev;
  logic [FW-1:0]   amp;
  logic [CXW-1:0]  cx_nxt, cx2_r;
  logic [L6W-1:0]  l60_nxt, l60_2_r, l60_3_r;
  logic signed [6:0] cr2_r, cg2_r, cb2_r;

  assign two_l   = {l1_r, 1'b0};
  assign one_w   = (FW + 1)'(1) << FRAC_BITS;
  assign dev     = (two_l >= one_w) ? (two_l - one_w) : (one_w - two_l);
  assign amp     = FW'(one_w - dev);
  assign cx_nxt  = CXW'(amp) * CXW'(s1_r);
  assign l60_nxt = L6W'(l1_r) * L6W'(SECTOR_DEG);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    e2_r    <= e1_r;
    cx2_r   <= cx_nxt;
    l60_2_r <= l60_nxt;
    cr2_r   <= cr1_r;
    cg2_r   <= cg1_r;
    cb2_r   <= cb1_r;
  end

  // ---------------- Stage 3: chroma times channel weight ----------------
  logic signed [CXW:0]  cx_s;
  logic signed [PW-1:0] pr3_r, pg3_r, pb3_r;

  assign cx_s = $signed({1'b0, cx2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    e3_r    <= e2_r;
    l60_3_r <= l60_2_r;
    pr3_r   <= PW'(cx_s) * PW'(cr2_r);
    pg3_r   <= PW'(cx_s) * PW'(cg2_r);
    pb3_r   <= PW'(cx_s) * PW'(cb2_r);
  end

  // ---------------- Stage 4: add lightness, drop fraction bits ----------------
  // A channel in 0..1 sits at 60 * 2^(2F); red and blue are scaled by 8/15,
  // green by 16/15, so the shift keeps eight or sixteen times the value.
  logic signed [PW-1:0] lterm, vr, vg, vb;
  logic [8:0] ur4_r, ub4_r;
  logic [9:0] ug4_r;

  assign lterm = $signed({1'b0, l60_3_r, {FRAC_BITS{1'b0}}});
  assign vr    = pr3_r + lterm;
  assign vg    = pg3_r + lterm;
  assign vb    = pb3_r + lterm;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    e4_r  <= e3_r;
    ur4_r <= vr[2*FRAC_BITS+5 : 2*FRAC_BITS-3];
    ub4_r <= vb[2*FRAC_BITS+5 : 2*FRAC_BITS-3];
    ug4_r <= vg[2*FRAC_BITS+5 : 2*FRAC_BITS-4];
  end

  // ---------------- Stage 5: divide by fifteen, saturate, pack ----------------
  logic [4:0] red, blue;
  logic [5:0] green;
  hsl_out_t   out_nxt, out_r;

  always_comb begin
    red   = (ur4_r >= 9'(RB_SAT_LIMIT)) ? 5'(RB_MAX) : 5'(div15(10'(ur4_r)));
    blue  = (ub4_r >= 9'(RB_SAT_LIMIT)) ? 5'(RB_MAX) : 5'(div15(10'(ub4_r)));
    green = (ug4_r >= 10'(G_SAT_LIMIT)) ? 6'(G_MAX) : 6'(div15(ug4_r));
    out_nxt.hue_error = e4_r;
    if (e4_r) begin
      out_nxt.color = '0;
    end else begin
      out_nxt.color = {red, green, blue};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    out_r <= out_nxt;
  end

  assign out_strobe = v5_r;
  assign out_word   = out_r;

  // ---------------- Checks ----------------
  // A bad hue always comes out as a black pixel.
  a_err_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_word.hue_error |-> out_word.color == 16'd0)
    else $error("hue error with nonzero color");

  // The last valid bit follows the one before it in the next cycle.
  a_valid_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(v4_r))
    else $error("result strobe without a word in the stage before");

  // A word enters the pipe only where start was raised.
  a_entry: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> $past(start))
    else $error("first stage valid without start");

  // Reset empties the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

endmodule
